@@ sv/ifps_pkg.sv @@
// ---------------------------------------------------------------------------
// ifps_pkg: shared types for the interval follow/precede search
// Operation codes and the beat that travels along the row of subject cells.
// ---------------------------------------------------------------------------
`default_nettype none

package ifps_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned INDEX_W = 10;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_FOLLOW  = 2'd1,
      OP_PRECEDE = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   // one beat in flight along the row; index and count travel beside it
   typedef struct packed {
      logic                       valid;
      op_type                     op;
      logic signed [COORD_W-1:0]  subject_start;
      logic signed [COORD_W-1:0]  subject_end;
      logic signed [COORD_W-1:0]  query_position;
      logic                       hit;
      logic signed [COORD_W-1:0]  best_val;
   } beat_type;

endpackage

`default_nettype wire

@@ sv/ifps_if.sv @@
// ---------------------------------------------------------------------------
// ifps_if: request and response channels
// Valid/ready channels; a beat moves on an edge with valid and ready high.
// ---------------------------------------------------------------------------
`default_nettype none

interface ifps_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             operation;
   logic signed [ifps_pkg::COORD_W-1:0]    subject_start;
   logic signed [ifps_pkg::COORD_W-1:0]    subject_end;
   logic signed [ifps_pkg::COORD_W-1:0]    query_position;

   modport source (output valid, operation, subject_start, subject_end, query_position,
                   input ready);
   modport sink   (input valid, operation, subject_start, subject_end, query_position,
                   output ready);
endinterface

interface ifps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               found;
   logic [ifps_pkg::INDEX_W-1:0]       subject_index;

   modport source (output valid, found, subject_index, input ready);
   modport sink   (input valid, found, subject_index, output ready);
endinterface

`default_nettype wire

@@ sv/ifps_head.sv @@
// ---------------------------------------------------------------------------
// ifps_head: entry of the cell row
// Takes request beats, keeps the subject count and tags each beat with it.
// ---------------------------------------------------------------------------
`default_nettype none

module ifps_head #(
   parameter int unsigned MAX_SUBJECTS = 1024,
   parameter int unsigned CNT_W        = 11,
   parameter int unsigned IDX_W        = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   ifps_req_if.sink              req_bus,
   output ifps_pkg::beat_type    beat_o,
   output logic [CNT_W-1:0]      count_o,
   output logic [IDX_W-1:0]      idx_o
);

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   ifps_pkg::op_type   op;
   logic               accept;

   assign op      = ifps_pkg::op_type'(req_bus.operation);
   assign accept  = req_bus.valid && adv;
   assign req_bus.ready = adv;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         case (op)
            ifps_pkg::OP_LOAD: begin
               if (count_ff < CNT_W'(MAX_SUBJECTS)) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ifps_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // a load carries its slot in count; a full table matches no cell
   always_comb begin
      beat_o.valid          = req_bus.valid;
      beat_o.op             = op;
      beat_o.subject_start  = req_bus.subject_start;
      beat_o.subject_end    = req_bus.subject_end;
      beat_o.query_position = req_bus.query_position;
      beat_o.hit            = 1'b0;
      beat_o.best_val       = '0;
      count_o               = count_ff;
      idx_o                 = '0;
   end

endmodule

`default_nettype wire

@@ sv/ifps_cell.sv @@
// ---------------------------------------------------------------------------
// ifps_cell: one subject slot of the row
// Holds one subject range and updates the running best of a passing query.
// ---------------------------------------------------------------------------
`default_nettype none

module ifps_cell #(
   parameter int unsigned CNT_W      = 11,
   parameter int unsigned IDX_W      = 10,
   parameter int unsigned CELL_INDEX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire ifps_pkg::beat_type  beat_i,
   input  wire logic [CNT_W-1:0]    count_i,
   input  wire logic [IDX_W-1:0]    idx_i,
   output ifps_pkg::beat_type       beat_o,
   output logic [CNT_W-1:0]         count_o,
   output logic [IDX_W-1:0]         idx_o
);

   localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(CELL_INDEX);
   localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(CELL_INDEX);

   logic signed [ifps_pkg::COORD_W-1:0] start_ff;
   logic signed [ifps_pkg::COORD_W-1:0] end_ff;
   ifps_pkg::beat_type                  beat_ff;
   ifps_pkg::beat_type                  beat_in;
   logic [CNT_W-1:0]                    count_ff;
   logic [IDX_W-1:0]                    idx_ff;
   logic [IDX_W-1:0]                    idx_in;
   logic                                live;
   logic                                load_here;

   assign live      = count_i > MY_SLOT;
   assign load_here = beat_i.valid && (beat_i.op == ifps_pkg::OP_LOAD) && (count_i == MY_SLOT);

   always_comb begin
      beat_in = beat_i;
      idx_in  = idx_i;
      case (beat_i.op)
         ifps_pkg::OP_FOLLOW: begin
            // greatest end below the position; later slots win ties
            if (live && (end_ff < beat_i.query_position) &&
                (!beat_i.hit || (end_ff >= beat_i.best_val))) begin
               beat_in.hit      = 1'b1;
               beat_in.best_val = end_ff;
               idx_in           = MY_IDX;
            end
         end
         ifps_pkg::OP_PRECEDE: begin
            // least start at or above the position; earlier slots keep ties
            if (live && (start_ff >= beat_i.query_position) &&
                (!beat_i.hit || (start_ff < beat_i.best_val))) begin
               beat_in.hit      = 1'b1;
               beat_in.best_val = start_ff;
               idx_in           = MY_IDX;
            end
         end
         default: begin
            beat_in = beat_i;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv && load_here) begin
         start_ff <= beat_i.subject_start;
         end_ff   <= beat_i.subject_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (adv) begin
         beat_ff  <= beat_in;
         count_ff <= count_i;
         idx_ff   <= idx_in;
      end
   end

   assign beat_o  = beat_ff;
   assign count_o = count_ff;
   assign idx_o   = idx_ff;

endmodule

`default_nettype wire

@@ sv/ifps_tail.sv @@
// ---------------------------------------------------------------------------
// ifps_tail: exit of the cell row
// Registers query results for the response channel and drives the row advance.
// ---------------------------------------------------------------------------
`default_nettype none

module ifps_tail #(
   parameter int unsigned IDX_W = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ifps_pkg::beat_type  beat_i,
   input  wire logic [IDX_W-1:0]    idx_i,
   output logic                     adv,
   ifps_rsp_if.source               rsp_bus
);

   logic                          rsp_valid_ff;
   logic                          found_ff;
   logic [ifps_pkg::INDEX_W-1:0]  index_ff;
   logic                          is_query;

   assign adv      = !rsp_valid_ff || rsp_bus.ready;
   assign is_query = (beat_i.op == ifps_pkg::OP_FOLLOW) ||
                     (beat_i.op == ifps_pkg::OP_PRECEDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= beat_i.valid && is_query;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         found_ff <= beat_i.hit;
         index_ff <= beat_i.hit ? ifps_pkg::INDEX_W'(idx_i) : '0;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.found         = found_ff;
   assign rsp_bus.subject_index = index_ff;

endmodule

`default_nettype wire

@@ sv/interval_follow_precede_search.sv @@
// ---------------------------------------------------------------------------
// interval_follow_precede_search: follow/precede search over subject ranges
// Row of subject cells; every beat walks the row, queries pick a running best.
// ---------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  req_bus   in   req_bus.valid/ready  operation, subject_start, subject_end,
//                                      query_position
//  rsp_bus   out  rsp_bus.valid/ready  found, subject_index (queries only)
//
//  One beat enters per cycle unless a held response stalls the row; a query
//  result is registered by each cell, then by the tail response register.
//  A held response stalls the whole row, req_bus.ready included.
//  Reset clears the subject count and the beat valid bits; the stored ranges
//  are not cleared, since only slots below the count take part in a query.
// ---------------------------------------------------------------------------
`default_nettype none

module interval_follow_precede_search #(
   parameter int unsigned MAX_SUBJECTS = 1024
) (
   input  wire logic     clock,
   input  wire logic     reset,
   ifps_req_if.sink      req_bus,
   ifps_rsp_if.source    rsp_bus
);

   localparam int unsigned CNT_W = $clog2(MAX_SUBJECTS + 1);
   localparam int unsigned IDX_W = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;

   ifps_pkg::beat_type  beat_chain  [MAX_SUBJECTS+1];
   logic [CNT_W-1:0]    count_chain [MAX_SUBJECTS+1];
   logic [IDX_W-1:0]    idx_chain   [MAX_SUBJECTS+1];
   logic                adv;

   ifps_head #(
      .MAX_SUBJECTS (MAX_SUBJECTS),
      .CNT_W        (CNT_W),
      .IDX_W        (IDX_W)
   ) u_head (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .req_bus (req_bus),
      .beat_o  (beat_chain[0]),
      .count_o (count_chain[0]),
      .idx_o   (idx_chain[0])
   );

   for (genvar k = 0; k < MAX_SUBJECTS; k++) begin : g_cell
      ifps_cell #(
         .CNT_W      (CNT_W),
         .IDX_W      (IDX_W),
         .CELL_INDEX (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .beat_i  (beat_chain[k]),
         .count_i (count_chain[k]),
         .idx_i   (idx_chain[k]),
         .beat_o  (beat_chain[k+1]),
         .count_o (count_chain[k+1]),
         .idx_o   (idx_chain[k+1])
      );
   end

   ifps_tail #(
      .IDX_W (IDX_W)
   ) u_tail (
      .clock   (clock),
      .reset   (reset),
      .beat_i  (beat_chain[MAX_SUBJECTS]),
      .idx_i   (idx_chain[MAX_SUBJECTS]),
      .adv     (adv),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

@@ sv/ifps_checker.sv @@
// ---------------------------------------------------------------------------
// ifps_checker: port-level checks for the follow/precede search
// Watches the request and response ports of the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ifps_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_found,
   input wire logic [ifps_pkg::INDEX_W-1:0]  rsp_subject_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_subject_index))
      else $error("response payload changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_subject_index == '0)
      else $error("miss reported with nonzero index");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind interval_follow_precede_search ifps_checker u_ifps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_found         (rsp_bus.found),
   .rsp_subject_index (rsp_bus.subject_index)
);

`default_nettype wire
